### hdl/chml_pkg.sv
// Package for the cache tag lookup block: sizes, state enum, command/status structs.
// Used by chml_ctrl, chml_dp and cache_hit_miss_lookup_top.
package chml_pkg;

    localparam int LINES          = 256;
    localparam int SETS           = 4;
    localparam int ADDR_BITS      = 32;
    localparam int MAX_WORDS_LOG2 = 8;
    localparam int LINE_W         = $clog2(LINES);
    localparam int SET_W          = $clog2(SETS);
    localparam int WAY_W          = LINE_W - SET_W;
    localparam int CNT_W          = LINE_W + 1;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_POLICY = 2'd1;
    localparam logic [1:0] REG_LINES  = 2'd2;
    localparam logic [1:0] REG_WORDS  = 2'd3;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic assoc;
        logic scan_last;
    } stat_t;

endpackage

### hdl/cache_hit_miss_lookup_top.sv
// Cache tag lookup top level: wires the controller to the datapath.
// Depends on chml_pkg, chml_ctrl, chml_dp.
//
// Usage: one word address enters on address/in_valid, accepted when in_stall
// is low. One result word leaves on out_valid, taken when out_stall is low:
// hit, line, block_base, config_error and saturating hit/miss totals.
// Configuration writes (cfg_index, cfg_data) complete on cfg_valid and
// cfg_ready; cfg_ready is high only while no word is in flight or offered.
// Direct mapped: after accept the word passes SETUP, WAIT, DECIDE and OUT;
// associative adds SCAN over the ways (ways = lines/4, up to 64), one way
// read per cycle from the tag and stamp memories. One word in flight at a
// time, so a new word is taken only after the result has left.
// Reset: all lines invalid, stamp clock and counters zero, LFSR seeded,
// registers at defaults. A stalled result holds; no new word is taken.
module cache_hit_miss_lookup_top
    import chml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [7:0]  line,
    output logic [31:0] block_base,
    output logic        config_error,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    chml_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    chml_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index[1:0]),
        .cfg_data     (cfg_data[3:0]),
        .cfg_hi       (cfg_index[31:2] != '0),
        .address      (address),
        .cmd          (cmd),
        .stat         (stat),
        .hit          (hit),
        .line         (line),
        .block_base   (block_base),
        .config_error (config_error),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

endmodule

### hdl/chml_ctrl.sv
// Controller state machine for the cache tag lookup block.
// Depends on chml_pkg; drives chml_dp through cmd_t, reads stat_t.
module chml_ctrl
    import chml_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    output logic   out_valid,
    input  logic   out_stall,
    output logic   cfg_ready,
    output cmd_t   cmd,
    input  stat_t  stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SETUP;
            ST_SETUP:  state_next = (stat.err || !stat.assoc) ? ST_WAIT : ST_SCAN;
            ST_SCAN:   if (stat.scan_last) state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:    if (!out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = !in_valid;
                cmd.load  = in_valid;
            end
            ST_SETUP:  cmd.scan_start = 1'b1;
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_WAIT:   ;
            ST_DECIDE: cmd.commit = 1'b1;
            ST_OUT:    out_valid = 1'b1;
            default:   ;
        endcase
    end

endmodule

### hdl/chml_dp.sv
// Datapath: config registers, tag/stamp memories, way scan, counters, result word.
// Depends on chml_pkg; controlled by chml_ctrl.
module chml_dp
    import chml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        cfg_hi,
    input  logic [31:0] address,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        hit,
    output logic [7:0]  line,
    output logic [31:0] block_base,
    output logic        config_error,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total
);

    logic mode_reg, policy_reg;
    logic [3:0] lines_log2_reg, words_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            policy_reg     <= 1'b0;
            lines_log2_reg <= 4'd8;
            words_log2_reg <= 4'd0;
        end
        else if (cfg_write && !cfg_hi)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg       <= cfg_data[0];
                REG_POLICY: policy_reg     <= cfg_data[0];
                REG_LINES:  lines_log2_reg <= cfg_data;
                REG_WORDS:  words_log2_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic [LINES-1:0]  valid_reg;
    logic [31:0]       tag_mem [LINES];
    logic [31:0]       use_mem [LINES];
    logic [31:0]       tag_rd_reg, use_rd_reg;
    logic [31:0]       clock_reg, hits_reg, misses_reg;
    logic [15:0]       lfsr_reg;

    logic [31:0] block_reg, tag_reg, base_reg;
    logic [LINE_W-1:0] first_reg, ln_reg, best_reg, inv_reg, cand_reg;
    logic [CNT_W-1:0]  ways_reg, scan_reg, pend_reg;
    logic        err_reg, hitf_reg, inv_found_reg, pend_valid_reg;
    logic [31:0] best_use_reg;
    logic        res_hit_reg, res_err_reg;
    logic [LINE_W-1:0] res_ln_reg;

    logic [3:0]  wl;
    logic [3:0]  ll;
    logic [31:0] blk, bas;
    logic [CNT_W-1:0] lines_n, ways_n;
    logic [LINE_W-1:0] rd_addr;

    always_comb
    begin
        wl = (words_log2_reg > 4'(MAX_WORDS_LOG2)) ? 4'(MAX_WORDS_LOG2) : words_log2_reg;
        ll = (lines_log2_reg > 4'(LINE_W)) ? 4'(LINE_W) : lines_log2_reg;
        blk = address >> wl;
        bas = blk << wl;
        lines_n = CNT_W'(1) << ll;
        ways_n  = lines_n >> SET_W;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            block_reg <= blk;
            base_reg  <= bas;
            ways_reg  <= ways_n;
            err_reg   <= mode_reg && (ways_n == '0);
            if (mode_reg)
            begin
                tag_reg   <= blk >> SET_W;
                first_reg <= LINE_W'(blk[SET_W-1:0]) << (ll - 4'(SET_W));
            end
            else
            begin
                tag_reg   <= blk >> ll;
                first_reg <= LINE_W'(blk & 32'((lines_n - 1'b1)));
            end
        end
    end

    always_comb
    begin
        stat.err       = err_reg;
        stat.assoc     = mode_reg;
        stat.scan_last = (scan_reg == ways_reg - 1'b1);
    end

    // memory read: scan walks ways in assoc mode; otherwise the single line
    always_comb
    begin
        if (cmd.scan_step)
            rd_addr = first_reg + LINE_W'(scan_reg);
        else
            rd_addr = first_reg;
    end

    logic [15:0] lfsr_n;
    assign lfsr_n = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    function automatic logic hit_sel();
        if (mode_reg)
            return hitf_reg;
        else
            return valid_reg[first_reg] && (tag_rd_reg == tag_reg);
    endfunction

    function automatic logic [LINE_W-1:0] ln_sel();
        logic [LINE_W-1:0] r;
        if (!mode_reg)
            r = first_reg;
        else if (hitf_reg)
            r = ln_reg;
        else if (policy_reg)
            r = first_reg + (LINE_W'(lfsr_n) & LINE_W'(ways_reg - 1'b1));
        else if (inv_found_reg)
            r = inv_reg;
        else
            r = best_reg;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        tag_rd_reg <= tag_mem[rd_addr];
        use_rd_reg <= use_mem[rd_addr];
        if (cmd.commit && !err_reg)
        begin
            use_mem[ln_sel()] <= clock_reg + 32'd1;
            if (!hit_sel())
                tag_mem[ln_sel()] <= tag_reg;
        end
    end

    // evaluation of previous read (registered, in the cycle after its address)
    logic eval_hit;
    assign eval_hit = valid_reg[cand_reg] && (tag_rd_reg == tag_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hitf_reg       <= 1'b0;
            inv_found_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            pend_valid_reg <= cmd.scan_step || cmd.scan_start;
            cand_reg       <= rd_addr;
            pend_reg       <= scan_reg;
            if (cmd.scan_step)
                scan_reg <= scan_reg + 1'b1;
            if (pend_valid_reg && mode_reg && (pend_reg != '0 || !cmd.commit))
            begin
                if (!hitf_reg && eval_hit)
                begin
                    hitf_reg <= 1'b1;
                    ln_reg   <= cand_reg;
                end
                if (!inv_found_reg && !valid_reg[cand_reg])
                begin
                    inv_found_reg <= 1'b1;
                    inv_reg       <= cand_reg;
                end
                if (pend_reg == '0 || use_rd_reg < best_use_reg)
                begin
                    best_use_reg <= use_rd_reg;
                    best_reg     <= cand_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            clock_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            lfsr_reg   <= LFSR_SEED;
        end
        else if (cmd.commit && !err_reg)
        begin
            clock_reg <= clock_reg + 32'd1;
            if (mode_reg)
                lfsr_reg <= lfsr_n;
            if (hit_sel())
            begin
                if (hits_reg != '1)
                    hits_reg <= hits_reg + 32'd1;
            end
            else
            begin
                if (misses_reg != '1)
                    misses_reg <= misses_reg + 32'd1;
                valid_reg[ln_sel()] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_err_reg <= err_reg;
            res_hit_reg <= !err_reg && hit_sel();
            res_ln_reg  <= err_reg ? '0 : ln_sel();
        end
    end

    assign hit          = res_hit_reg;
    assign line         = 8'(res_ln_reg);
    assign block_base   = res_err_reg ? 32'd0 : base_reg;
    assign config_error = res_err_reg;
    assign hit_total    = hits_reg;
    assign miss_total   = misses_reg;

endmodule

### tb/cache_hit_miss_lookup_top_tb.sv
// Testbench for cache_hit_miss_lookup_top: directed table then random addresses,
// checked against a behavioral cache lookup predictor. Depends on chml_pkg and the RTL.
module cache_hit_miss_lookup_top_tb;
    import chml_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [7:0]  line;
        logic [31:0] block_base;
        logic        config_error;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } lookup_t;

    typedef struct {
        bit          is_cfg;
        logic [31:0] idx;
        logic [31:0] val;
        bit          known;
        lookup_t     res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] address;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic [7:0]  line;
    logic [31:0] block_base;
    logic        config_error;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_index;
    logic [31:0] cfg_data;

    cache_hit_miss_lookup_top u_top (.*);

    // predictor state
    logic        m_mode;
    logic        m_policy;
    logic [3:0]  m_lines_log2;
    logic [3:0]  m_words_log2;
    bit          m_valid[LINES];
    logic [31:0] m_tag[LINES];
    logic [31:0] m_stamp[LINES];
    logic [31:0] m_clock;
    logic [15:0] m_lfsr;
    logic [31:0] m_hits;
    logic [31:0] m_misses;

    lookup_t pending_q[$];
    int      errors;
    int      idle_cycles;
    bit      quiet;
    bit      run_done;

    function automatic void predict_reset();
        m_mode = 0; m_policy = 0; m_lines_log2 = 8; m_words_log2 = 0;
        for (int i = 0; i < LINES; i++)
        begin
            m_valid[i] = 0; m_tag[i] = 0; m_stamp[i] = 0;
        end
        m_clock = 0; m_lfsr = LFSR_SEED; m_hits = 0; m_misses = 0;
    endfunction

    function automatic void predict_config(logic [31:0] idx, logic [31:0] val);
        if (idx == 32'(REG_MODE))
            m_mode = val[0];
        else if (idx == 32'(REG_POLICY))
            m_policy = val[0];
        else if (idx == 32'(REG_LINES))
            m_lines_log2 = val[3:0];
        else if (idx == 32'(REG_WORDS))
            m_words_log2 = val[3:0];
    endfunction

    function automatic lookup_t predict_lookup(logic [31:0] addr);
        lookup_t r;
        int unsigned wl, nlines, ways, first, ln, blk, tg;
        bit h, found;
        wl = (m_words_log2 > MAX_WORDS_LOG2) ? MAX_WORDS_LOG2 : m_words_log2;
        nlines = (m_lines_log2 >= 8) ? LINES : (1 << m_lines_log2);
        blk = addr >> wl;
        h = 0; ln = 0;
        r.config_error = 0;
        if (!m_mode)
        begin
            ln = blk % nlines;
            tg = blk / nlines;
            h = m_valid[ln] && m_tag[ln] == tg;
        end
        else
        begin
            ways = nlines / SETS;
            if (ways == 0)
            begin
                r = '{0, 0, 0, 1, m_hits, m_misses};
                return r;
            end
            first = (blk % SETS) * ways;
            tg = blk / SETS;
            m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ LFSR_TAPS) : (m_lfsr >> 1);
            for (int i = 0; i < ways && !h; i++)
                if (m_valid[first + i] && m_tag[first + i] == tg)
                begin
                    h = 1; ln = first + i;
                end
            if (!h)
            begin
                if (m_policy)
                    ln = first + m_lfsr % ways;
                else
                begin
                    found = 0; ln = first;
                    for (int i = 0; i < ways && !found; i++)
                        if (!m_valid[first + i])
                        begin
                            found = 1; ln = first + i;
                        end
                    if (!found)
                        for (int i = 1; i < ways; i++)
                            if (m_stamp[first + i] < m_stamp[ln])
                                ln = first + i;
                end
            end
        end
        m_clock++;
        if (h)
        begin
            if (m_hits != '1) m_hits++;
        end
        else
        begin
            if (m_misses != '1) m_misses++;
            m_valid[ln] = 1;
            m_tag[ln] = tg;
        end
        m_stamp[ln] = m_clock;
        r.hit = h;
        r.line = ln[7:0];
        r.block_base = blk << wl;
        r.hit_total = m_hits;
        r.miss_total = m_misses;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result checker
    always @(posedge clk)
    begin
        lookup_t e;
        if (out_valid && !out_stall && rst_n)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with no expectation");
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit exp %0h got %0h", e.hit, hit); errors++;
                end
                if (line !== e.line)
                begin
                    $error("line exp %0h got %0h", e.line, line); errors++;
                end
                if (block_base !== e.block_base)
                begin
                    $error("block_base exp %0h got %0h", e.block_base, block_base); errors++;
                end
                if (config_error !== e.config_error)
                begin
                    $error("config_error exp %0h got %0h", e.config_error, config_error);
                    errors++;
                end
                if (hit_total !== e.hit_total)
                begin
                    $error("hit_total exp %0h got %0h", e.hit_total, hit_total); errors++;
                end
                if (miss_total !== e.miss_total)
                begin
                    $error("miss_total exp %0h got %0h", e.miss_total, miss_total); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !run_done)
        begin
            $display("** cache_hit_miss_lookup_top: FAILED **");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 6);

    task automatic send_word(logic [31:0] addr, bit known, lookup_t exp_r);
        lookup_t p;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 6)
            @(negedge clk);
        p = predict_lookup(addr);
        if (known && p != exp_r)
        begin
            $error("table row for address %0h disagrees with predictor", addr);
            errors++;
        end
        pending_q.push_back(p);
        in_valid <= 1;
        address <= addr;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic write_reg(logic [31:0] idx, logic [31:0] val);
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        predict_config(idx, val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] pick_addr(int hot);
        case ($urandom_range(9))
            0: return $urandom();
            1: return {$urandom_range(1) ? 32'hFFFF_FF00 : 32'h0} | $urandom_range(255);
            default: return ($urandom_range(hot) << $urandom_range(8)) ^ $urandom_range(7);
        endcase
    endfunction

    row_t    dir[$];
    lookup_t z;

    initial
    begin
        errors = 0; idle_cycles = 0; quiet = 0; run_done = 0;
        in_valid = 0; address = 0; out_stall = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        z = '{0, 0, 0, 0, 0, 0};
        predict_reset();
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        dir = '{
            '{0, 0, 32'h0000_0000, 1, '{0, 8'h00, 32'h0000_0000, 0, 0, 1}},
            '{0, 0, 32'h0000_0000, 1, '{1, 8'h00, 32'h0000_0000, 0, 1, 1}},
            '{0, 0, 32'hFFFF_FFFF, 1, '{0, 8'hFF, 32'hFFFF_FFFF, 0, 1, 2}},
            '{0, 0, 32'h0000_0100, 0, z}, '{0, 0, 32'h0000_0000, 0, z},
            '{1, 32'(REG_WORDS), 32'd8, 0, z},
            '{0, 0, 32'hFFFF_FFFF, 0, z}, '{0, 0, 32'h1234_5678, 0, z},
            '{1, 32'(REG_WORDS), 32'd15, 0, z}, '{0, 0, 32'h0000_ABCD, 0, z},
            '{1, 32'(REG_WORDS), 32'd0, 0, z},
            '{1, 32'(REG_MODE), 32'd1, 0, z}, '{1, 32'(REG_LINES), 32'd1, 0, z},
            '{0, 0, 32'h0000_0005, 0, z},
            '{1, 32'(REG_LINES), 32'd15, 0, z},
            '{0, 0, 32'h0000_0001, 0, z}, '{0, 0, 32'h0000_0401, 0, z},
            '{1, 32'(REG_LINES), 32'd3, 0, z},
            '{0, 0, 32'h0000_0002, 0, z}, '{0, 0, 32'h0000_0006, 0, z},
            '{0, 0, 32'h0000_000A, 0, z}, '{0, 0, 32'h0000_0002, 0, z},
            '{1, 32'(REG_POLICY), 32'd1, 0, z}, '{0, 0, 32'h0000_000E, 0, z},
            '{1, 32'd7, 32'hFFFF_FFFF, 0, z}, '{0, 0, 32'h8000_0003, 0, z}
        };
        foreach (dir[i])
        begin
            if (dir[i].is_cfg)
                write_reg(dir[i].idx, dir[i].val);
            else
                send_word(dir[i].val, dir[i].known, dir[i].res);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            int hot;
            write_reg(32'(REG_MODE), ph % 2);
            write_reg(32'(REG_POLICY), (ph / 2) % 2);
            write_reg(32'(REG_LINES), (ph == 0) ? 8 : (ph == 1) ? 1 : $urandom_range(15));
            write_reg(32'(REG_WORDS), (ph == 9) ? 15 : $urandom_range(9) == 0 ? 8 : $urandom_range(3));
            hot = $urandom_range(1) ? 31 : 1023;
            quiet = (ph == 4);
            for (int n = 0; n < 125; n++)
                send_word(pick_addr(hot), 0, z);
            quiet = 0;
        end

        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        run_done = 1;
        if (errors == 0)
            $display("** cache_hit_miss_lookup_top: PASSED **");
        else
            $display("** cache_hit_miss_lookup_top: FAILED **");
        $finish;
    end
endmodule
